[rtl/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// gpg_pkg - shared constants and a helper for the gradient pixel generator
// Register indices, rate codes, fixed datapath widths and the exp series.
// ----------------------------------------------------------------------------
package gpg_pkg;

  // configuration register indices
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_INNER  = 3'd1;
  localparam logic [2:0] REG_OUTER  = 3'd2;
  localparam logic [2:0] REG_SINE   = 3'd3;
  localparam logic [2:0] REG_COSINE = 3'd4;
  localparam logic [2:0] REG_CENTER = 3'd5;
  localparam logic [2:0] REG_RADII  = 3'd6;
  localparam logic [2:0] REG_GSIZE  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // mode decode
  localparam logic [2:0] MODE_MAX    = 3'd5;
  localparam logic [2:0] MODE_RADIAL = 3'd3;

  // opacity rates
  localparam logic [1:0] RATE_LIN = 2'd0;
  localparam logic [1:0] RATE_LOG = 2'd1;
  localparam logic [1:0] RATE_SQR = 2'd2;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam int          NUM_W    = 43;   // widest dividend (square rate)
  localparam int          DIV_W    = 26;   // widest divisor (d squared)
  localparam int          EXP_STEPS = 15;  // most powers of e(-1) applied
  localparam int          EXP_TERMS = 24;

  typedef logic [32:0] exp_q32_t;

  // exp(-k / 2^log_d) in Q32 by alternating series, evaluated at elaboration
  function automatic exp_q32_t exp_neg_q32(input logic [31:0] k, input int log_d);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    term = 64'd1 << 32;
    pos  = term;
    neg  = 64'd0;
    for (int j = 1; j <= EXP_TERMS; j++) begin
      term = ((term * 64'(k)) >> log_d) / 64'(j);
      if ((j % 2) == 1) neg = neg + term;
      else pos = pos + term;
    end
    return exp_q32_t'(pos - neg);
  endfunction

endpackage

[rtl/gradient_pixel_generator.sv]
// ----------------------------------------------------------------------------
// gradient_pixel_generator - linear / radial two-colour gradient, RGBA16
// Turns one pixel coordinate into its gradient colour, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//
//  channel | ports                         | beat contents
//  --------+-------------------------------+--------------------------------
//  input   | in_tvalid/in_tready/in_tdata  | col, row
//  output  | out_tvalid/out_tready/out_tdata| red, green, blue, alpha
//  config  | cfg_we/cfg_idx/cfg_wdata      | one register write per cycle
//
//  One pixel enters every clock while the skid register is empty. The
//  pipeline has one stage per square-root bit (RB) and one stage per
//  quotient bit of the opacity divider (QW).
//  Reset is synchronous; it clears valid bits and sets configuration registers to defaults.
//  A skid register behind the output register catches the beat that is in
//  flight when out_tready drops; while it is full the whole pipeline holds.
//
module gradient_pixel_generator #(
  parameter int COORD_BITS      = 12,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // col[11:0], row[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // red, green, blue, alpha (16 bits each)
  input  logic                             cfg_we,
  input  logic [gpg_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [gpg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CB    = COORD_BITS;
  localparam int PW    = (CB + 4 > 16) ? CB + 4 : 16;   // magnitude bits of a Q4 offset
  localparam int DW    = PW + 1;                        // signed offset width
  localparam int SQ_W  = 2 * PW + 2;                    // radicand width, even
  localparam int RB    = PW + 1;                        // root bits
  localparam int RW    = RB + 3;                        // root remainder work width
  localparam int VW    = DW + 18;                       // linear distance accumulator
  localparam int LOG_D = $clog2(EXP_TABLE_DEPTH);
  localparam int QW    = (13 + LOG_D > 17) ? 13 + LOG_D : 17;
  localparam int NW    = gpg_pkg::NUM_W;
  localparam int DVW   = gpg_pkg::DIV_W;
  localparam int NS    = gpg_pkg::EXP_STEPS;

  localparam gpg_pkg::exp_q32_t E1 = gpg_pkg::exp_neg_q32(32'(EXP_TABLE_DEPTH), LOG_D);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]         mode_r;
  logic [31:0]        inner_r;
  logic [31:0]        outer_r;
  logic signed [15:0] sin_r;
  logic signed [15:0] cos_r;
  logic [31:0]        center_r;
  logic [25:0]        radii_r;
  logic [12:0]        gsize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 3'd0;
      inner_r  <= 32'hFFFF_FFFF;
      outer_r  <= 32'd0;
      sin_r    <= 16'sd0;
      cos_r    <= 16'sd16384;
      center_r <= 32'd0;
      radii_r  <= 26'd0;
      gsize_r  <= 13'd5793;
    end else if (cfg_we) begin
      case (cfg_idx)
        gpg_pkg::REG_MODE:   mode_r   <= cfg_wdata[2:0];
        gpg_pkg::REG_INNER:  inner_r  <= cfg_wdata;
        gpg_pkg::REG_OUTER:  outer_r  <= cfg_wdata;
        gpg_pkg::REG_SINE:   sin_r    <= signed'(cfg_wdata[15:0]);
        gpg_pkg::REG_COSINE: cos_r    <= signed'(cfg_wdata[15:0]);
        gpg_pkg::REG_CENTER: center_r <= cfg_wdata;
        gpg_pkg::REG_RADII:  radii_r  <= cfg_wdata[25:0];
        gpg_pkg::REG_GSIZE:  gsize_r  <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Decoded settings; the user must write them only while the pipeline is
  // empty, which the block does not enforce, so every stage reads them directly.
  logic [2:0]  mode_c;
  logic        radial_c;
  logic [1:0]  rate_c;
  logic [12:0] gs_c;
  logic [12:0] gs_m1_c;
  logic [12:0] ra_c;
  logic [12:0] rb_c;
  logic [12:0] rd_c;

  always_comb begin
    mode_c   = (mode_r > gpg_pkg::MODE_MAX) ? gpg_pkg::MODE_MAX : mode_r;
    radial_c = (mode_c >= gpg_pkg::MODE_RADIAL);
    rate_c   = radial_c ? 2'(mode_c - gpg_pkg::MODE_RADIAL) : mode_c[1:0];
    gs_c     = (gsize_r == 13'd0) ? 13'd1 : gsize_r;
    gs_m1_c  = gs_c - 13'd1;
    // swap inverted radii
    if (radii_r[12:0] > radii_r[25:13]) begin
      ra_c = radii_r[25:13];
      rb_c = radii_r[12:0];
    end else begin
      ra_c = radii_r[12:0];
      rb_c = radii_r[25:13];
    end
    rd_c = rb_c - ra_c;
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves together unless the skid is full
  // --------------------------------------------------------------------------
  logic en;
  logic skid_vld_r;
  assign en        = !skid_vld_r;
  assign in_tready = en;

  // A: capture the coordinate, wrapped to COORD_BITS
  logic          a_vld_r;
  logic [CB-1:0] a_col_r;
  logic [CB-1:0] a_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
      a_col_r <= CB'(in_tdata[11:0]);
      a_row_r <= CB'(in_tdata[23:12]);
    end
  end

  // B: Q4 offsets from the centre
  logic                 b_vld_r;
  logic signed [DW-1:0] b_dx_r;
  logic signed [DW-1:0] b_dy_r;
  logic signed [DW-1:0] col_q4;
  logic signed [DW-1:0] row_q4;
  logic signed [DW-1:0] cx_q4;
  logic signed [DW-1:0] cy_q4;

  assign col_q4 = signed'(DW'({a_col_r, 4'b0000}));
  assign row_q4 = signed'(DW'({a_row_r, 4'b0000}));
  assign cx_q4  = signed'(DW'(center_r[31:16]));
  assign cy_q4  = signed'(DW'(center_r[15:0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
      b_dx_r  <= col_q4 - cx_q4;
      b_dy_r  <= row_q4 - cy_q4;
    end
  end

  // C: squares for the radial shape, rotation products for the linear one
  logic                     c_vld_r;
  logic [2*PW-1:0]          c_dxx_r;
  logic [2*PW-1:0]          c_dyy_r;
  logic signed [DW+15:0]    c_xs_r;
  logic signed [DW+15:0]    c_yc_r;
  logic signed [2*DW-1:0]   dxx_nxt;
  logic signed [2*DW-1:0]   dyy_nxt;
  logic signed [DW+15:0]    xs_nxt;
  logic signed [DW+15:0]    yc_nxt;

  always_comb begin
    dxx_nxt = b_dx_r * b_dx_r;
    dyy_nxt = b_dy_r * b_dy_r;
    xs_nxt  = b_dx_r * sin_r;
    yc_nxt  = b_dy_r * cos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
      c_dxx_r <= dxx_nxt[2*PW-1:0];
      c_dyy_r <= dyy_nxt[2*PW-1:0];
      c_xs_r  <= xs_nxt;
      c_yc_r  <= yc_nxt;
    end
  end

  // D: radicand and rotated coordinate (y axis points up, hence dy*cos subtracts)
  logic                 d_vld_r;
  logic [SQ_W-1:0]      d_s_r;
  logic signed [VW-1:0] d_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= c_vld_r;
      d_s_r   <= SQ_W'(c_dxx_r) + SQ_W'(c_dyy_r);
      d_p_r   <= VW'(c_xs_r) - VW'(c_yc_r);
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one root bit per stage. Entry 0 also takes the clamped
  // linear distance, which then rides along.
  // --------------------------------------------------------------------------
  logic            sq_vld_r  [RB+1];
  logic [RW-1:0]   sq_rem_r  [RB+1];
  logic [RB-1:0]   sq_root_r [RB+1];
  logic [SQ_W-1:0] sq_s_r    [RB+1];
  logic [12:0]     sq_lin_r  [RB+1];

  logic signed [VW-1:0] lin_v;
  logic [DW-1:0]        lin_hi;
  logic [12:0]          lin_idx;

  always_comb begin
    lin_v  = signed'(VW'({gs_c[12:1], 18'd0})) - d_p_r + signed'(VW'(18'h20000));
    lin_hi = DW'(lin_v[VW-1:18]);
    if (lin_v < 0) lin_idx = 13'd0;
    else if (lin_hi > DW'(gs_m1_c)) lin_idx = gs_m1_c;
    else lin_idx = lin_hi[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0]  <= d_vld_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_s_r[0]    <= d_s_r;
      sq_lin_r[0]  <= lin_idx;
    end
  end

  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [RW-1:0] cur_nxt;
    logic [RW-1:0] trial_nxt;
    logic          ge_nxt;

    assign cur_nxt   = {sq_rem_r[j][RW-3:0], sq_s_r[j][SQ_W-1 -: 2]};
    assign trial_nxt = RW'({sq_root_r[j], 2'b01});
    assign ge_nxt    = (cur_nxt >= trial_nxt);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[j+1]  <= sq_vld_r[j];
        sq_rem_r[j+1]  <= ge_nxt ? (cur_nxt - trial_nxt) : cur_nxt;
        sq_root_r[j+1] <= {sq_root_r[j][RB-2:0], ge_nxt};
        sq_s_r[j+1]    <= sq_s_r[j] << 2;
        sq_lin_r[j+1]  <= sq_lin_r[j];
      end
    end
  end

  // M: pick the distance of the active shape, clamp to the table ends
  logic          m_vld_r;
  logic [12:0]   m_idx_r;
  logic [RB:0]   rad_sum;
  logic [RB-4:0] rad_pix;
  logic [12:0]   rad_idx;

  always_comb begin
    rad_sum = (RB+1)'(sq_root_r[RB]) + (RB+1)'(8);
    rad_pix = rad_sum[RB:4];
    rad_idx = (rad_pix > (RB-3)'(gs_m1_c)) ? gs_m1_c : rad_pix[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= sq_vld_r[RB];
      m_idx_r <= radial_c ? rad_idx : sq_lin_r[RB];
    end
  end

  // P: offset into the ramp, its square and d squared
  logic        p_vld_r;
  logic        p_lta_r;
  logic        p_geb_r;
  logic [12:0] p_diff_r;
  logic [25:0] p_t_r;
  logic [25:0] p_dd_r;
  logic [12:0] diff_nxt;

  assign diff_nxt = m_idx_r - ra_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r  <= m_vld_r;
      p_lta_r  <= (m_idx_r < ra_c);
      p_geb_r  <= (m_idx_r >= rb_c);
      p_diff_r <= diff_nxt;
      p_t_r    <= diff_nxt * diff_nxt;
      p_dd_r   <= rd_c * rd_c;
    end
  end

  // --------------------------------------------------------------------------
  // Rounded divider, one quotient bit per stage. The quotient is known to
  // fit in QW bits, so the dividend's upper part starts as the remainder.
  // --------------------------------------------------------------------------
  logic           dv_vld_r [QW+1];
  logic           dv_lta_r [QW+1];
  logic           dv_geb_r [QW+1];
  logic           dv_dz_r  [QW+1];
  logic [DVW-1:0] dv_rem_r [QW+1];
  logic [DVW-1:0] dv_dvs_r [QW+1];
  logic [QW-1:0]  dv_low_r [QW+1];
  logic [QW-1:0]  dv_q_r   [QW+1];

  logic [NW-1:0]  num_nxt;
  logic [DVW-1:0] dvs_nxt;

  always_comb begin
    case (rate_c)
      gpg_pkg::RATE_SQR: begin
        num_nxt = (NW'(p_t_r) << 16) + NW'(p_dd_r[25:1]);
        dvs_nxt = p_dd_r;
      end
      gpg_pkg::RATE_LOG: begin
        num_nxt = (NW'(p_diff_r) << LOG_D) + NW'(rd_c[12:1]);
        dvs_nxt = DVW'(rd_c);
      end
      default: begin
        num_nxt = (NW'(p_diff_r) << 16) + NW'(rd_c[12:1]);
        dvs_nxt = DVW'(rd_c);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= p_vld_r;
      dv_lta_r[0] <= p_lta_r;
      dv_geb_r[0] <= p_geb_r;
      dv_dz_r[0]  <= (rd_c == 13'd0);
      dv_rem_r[0] <= DVW'(num_nxt >> QW);
      dv_dvs_r[0] <= dvs_nxt;
      dv_low_r[0] <= num_nxt[QW-1:0];
      dv_q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DVW:0] cur_nxt;
    logic         ge_nxt;

    assign cur_nxt = {dv_rem_r[j], dv_low_r[j][QW-1]};
    assign ge_nxt  = (cur_nxt >= {1'b0, dv_dvs_r[j]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
        dv_lta_r[j+1] <= dv_lta_r[j];
        dv_geb_r[j+1] <= dv_geb_r[j];
        dv_dz_r[j+1]  <= dv_dz_r[j];
        dv_rem_r[j+1] <= ge_nxt ? DVW'(cur_nxt - {1'b0, dv_dvs_r[j]}) : DVW'(cur_nxt);
        dv_dvs_r[j+1] <= dv_dvs_r[j];
        dv_low_r[j+1] <= dv_low_r[j] << 1;
        dv_q_r[j+1]   <= {dv_q_r[j][QW-2:0], ge_nxt};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Exponential for the log rate: table entry for the fraction, then one
  // multiply by e(-1) per stage for each whole unit of the quotient
  // --------------------------------------------------------------------------
  gpg_pkg::exp_q32_t exp_rom [EXP_TABLE_DEPTH];

  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_rom
    assign exp_rom[g] = gpg_pkg::exp_neg_q32(32'(g), LOG_D);
  end

  logic              ex_vld_r  [NS+1];
  logic              ex_lta_r  [NS+1];
  logic              ex_dz_r   [NS+1];
  logic              ex_sat_r  [NS+1];
  logic [3:0]        ex_n_r    [NS+1];
  logic [16:0]       ex_opls_r [NS+1];
  gpg_pkg::exp_q32_t ex_v_r    [NS+1];

  logic [QW-LOG_D-1:0] whole_nxt;
  logic [16:0]         opls_nxt;

  always_comb begin
    whole_nxt = dv_q_r[QW][QW-1:LOG_D];
    if (dv_lta_r[QW]) opls_nxt = 17'd0;
    else if (dv_geb_r[QW]) opls_nxt = gpg_pkg::ONE_Q16;
    else opls_nxt = dv_q_r[QW][16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r[0] <= 1'b0;
    end else if (en) begin
      ex_vld_r[0]  <= dv_vld_r[QW];
      ex_lta_r[0]  <= dv_lta_r[QW];
      ex_dz_r[0]   <= dv_dz_r[QW];
      ex_sat_r[0]  <= (whole_nxt >= (QW-LOG_D)'(16));
      ex_n_r[0]    <= whole_nxt[3:0];
      ex_opls_r[0] <= opls_nxt;
      ex_v_r[0]    <= exp_rom[dv_q_r[QW][LOG_D-1:0]];
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_exp
    logic [64:0] prod_nxt;

    assign prod_nxt = (65'(ex_v_r[i]) * 65'(E1)) + 65'(33'h0_8000_0000);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ex_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        ex_vld_r[i+1]  <= ex_vld_r[i];
        ex_lta_r[i+1]  <= ex_lta_r[i];
        ex_dz_r[i+1]   <= ex_dz_r[i];
        ex_sat_r[i+1]  <= ex_sat_r[i];
        ex_n_r[i+1]    <= ex_n_r[i];
        ex_opls_r[i+1] <= ex_opls_r[i];
        ex_v_r[i+1]    <= (4'(i) < ex_n_r[i]) ? prod_nxt[64:32] : ex_v_r[i];
      end
    end
  end

  // O: final opacity, Q1.16 in 0..65536
  logic        o_vld_r;
  logic [16:0] o_op_r;
  logic [33:0] vr_nxt;
  logic [16:0] op_nxt;

  always_comb begin
    vr_nxt = 34'(ex_v_r[NS]) + 34'(16'h8000);
    if (rate_c != gpg_pkg::RATE_LOG) op_nxt = ex_opls_r[NS];
    else if (ex_lta_r[NS]) op_nxt = 17'd0;
    else if (ex_dz_r[NS] || ex_sat_r[NS]) op_nxt = gpg_pkg::ONE_Q16;
    else op_nxt = gpg_pkg::ONE_Q16 - vr_nxt[32:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= ex_vld_r[NS];
      o_op_r  <= op_nxt;
    end
  end

  // X: weight both colours per channel; F: sum, round, pack
  logic        x_vld_r;
  logic [32:0] x_po_r [4];
  logic [32:0] x_pi_r [4];
  logic [16:0] op_inv;

  assign op_inv = gpg_pkg::ONE_Q16 - o_op_r;

  for (genvar c = 0; c < 4; c++) begin : g_mix
    logic [7:0] ib;
    logic [7:0] ob;

    assign ib = inner_r[31-8*c -: 8];
    assign ob = outer_r[31-8*c -: 8];

    always_ff @(posedge clk) begin
      if (en) begin
        x_po_r[c] <= {ob, ob} * o_op_r;
        x_pi_r[c] <= {ib, ib} * op_inv;
      end
    end
  end

  logic        f_vld_r;
  logic [63:0] f_data_r;
  logic [63:0] f_nxt;

  always_comb begin
    logic [33:0] sum;
    f_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      sum = 34'(x_po_r[c]) + 34'(x_pi_r[c]) + 34'(16'h8000);
      f_nxt[16*c +: 16] = sum[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (en) begin
      x_vld_r  <= o_vld_r;
      f_vld_r  <= x_vld_r;
      f_data_r <= f_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid: a beat leaving the pipeline while the output
  // is stalled parks in the skid and holds the pipeline until it drains.
  // --------------------------------------------------------------------------
  logic        out_vld_r;
  logic [63:0] out_data_r;
  logic [63:0] skid_data_r;
  logic        push;

  assign push = en && f_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        out_data_r <= skid_data_r;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= push;
        out_data_r <= f_data_r;
      end
    end else if (push) begin
      skid_vld_r  <= 1'b1;
      skid_data_r <= f_data_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
